### hdl/kwm_pkg.sv
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared constants for the k-way sorted merge.
// ----------------------------------------------------------------------------
`default_nettype none
package kwm_pkg;
  localparam int LISTS_DEF      = 4;
  localparam int FIFO_DEPTH_DEF = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int MAX_RESULTS    = 64;
  localparam int IDX_W          = 2;
  localparam int KIND_W         = 3;
  localparam int CFG_W          = 3;
  localparam int CNT_W          = 7;

  localparam logic [KIND_W-1:0] KIND_MERGED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_EMPTY  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ORDER  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FULL   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLOSED = 3'd4;

  localparam logic FUNC_PUSH  = 1'b0;
  localparam logic FUNC_CLOSE = 1'b1;
endpackage
`default_nettype wire

### hdl/k_way_sorted_merge.sv
// ----------------------------------------------------------------------------
// k_way_sorted_merge
// Streaming merge of up to LISTS ascending signed sequences.
// ----------------------------------------------------------------------------
// Usage: requests (push a value or close a list) enter through push/full;
// results leave through empty/pop, oldest first, one per cycle at most.
// A two-entry request queue decouples the input from the merge engine, so
// requests are taken while a result waits.
// A refused request's result is registered as the engine takes it from the
// queue; a value that the request releases is registered later, in ST_PICK.
// A request passes through a take state (ST_IDLE) and a compare state
// (ST_PICK) per merged value; when the popped list still holds values its
// head is refetched from the value store (one read port) through a read
// state (ST_READ) and another compare state.
// Reset clears all lists, flags and queues; lists_in_use returns to the smaller of LISTS and 4.
// When the receiver stalls, the engine holds its result and the request
// queue fills and raises full.
// ----------------------------------------------------------------------------
`default_nettype none
module k_way_sorted_merge #(
  parameter int LISTS      = kwm_pkg::LISTS_DEF,
  parameter int FIFO_DEPTH = kwm_pkg::FIFO_DEPTH_DEF,
  parameter int DATA_WIDTH = kwm_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [kwm_pkg::CFG_W-1:0]   cfg_lists_in_use,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic                        in_func,
  input  wire logic [kwm_pkg::IDX_W-1:0]   in_list_index,
  input  wire logic [DATA_WIDTH-1:0]       in_value,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [kwm_pkg::KIND_W-1:0]       out_kind,
  output logic [DATA_WIDTH-1:0]            out_merged_value,
  output logic [kwm_pkg::IDX_W-1:0]        out_source_list,
  output logic                             out_round_done,
  output logic                             out_last
);
  import kwm_pkg::*;
  logic                  q_valid, q_take, q_func;
  logic [IDX_W-1:0]      q_idx;
  logic [DATA_WIDTH-1:0] q_value;

  kwm_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk, .rst_n, .push, .full, .in_func, .in_list_index, .in_value,
    .q_valid, .q_take, .q_func, .q_idx, .q_value
  );

  kwm_back #(.LISTS(LISTS), .FIFO_DEPTH(FIFO_DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk, .rst_n, .cfg_we, .cfg_data(cfg_lists_in_use),
    .q_valid, .q_take, .q_func, .q_idx, .q_value,
    .empty, .pop, .out_kind, .out_merged_value, .out_source_list,
    .out_round_done, .out_last
  );
endmodule
`default_nettype wire

### hdl/kwm_ram.sv
// ----------------------------------------------------------------------------
// kwm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module kwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

### hdl/kwm_front.sv
// ----------------------------------------------------------------------------
// kwm_front
// Request queue between the input port and the merge engine.
// ----------------------------------------------------------------------------
`default_nettype none
module kwm_front #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    push,
  output logic                         full,
  input  wire logic                    in_func,
  input  wire logic [kwm_pkg::IDX_W-1:0] in_list_index,
  input  wire logic [DATA_WIDTH-1:0]   in_value,
  output logic                         q_valid,
  input  wire logic                    q_take,
  output logic                         q_func,
  output logic [kwm_pkg::IDX_W-1:0]    q_idx,
  output logic [DATA_WIDTH-1:0]        q_value
);
  import kwm_pkg::*;
  localparam int W = 1 + IDX_W + DATA_WIDTH;

  logic [W-1:0] buf_r [2];
  logic         rp_r, wp_r;
  logic [1:0]   cnt_r;
  logic         wr, rd;

  assign full    = cnt_r[1];
  assign q_valid = cnt_r != 2'd0;
  assign wr      = push && !full;
  assign rd      = q_take && q_valid;
  assign {q_func, q_idx, q_value} = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) buf_r[wp_r] <= {in_func, in_list_index, in_value};
    if (!rst_n) begin
      rp_r <= 1'b0; wp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule
`default_nettype wire

### hdl/kwm_back.sv
// ----------------------------------------------------------------------------
// kwm_back
// Merge engine: list FIFOs, admission checks, head compare and result stage.
// ----------------------------------------------------------------------------
`default_nettype none
module kwm_back #(
  parameter int LISTS      = 4,
  parameter int FIFO_DEPTH = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [kwm_pkg::CFG_W-1:0] cfg_data,
  input  wire logic                      q_valid,
  output logic                           q_take,
  input  wire logic                      q_func,
  input  wire logic [kwm_pkg::IDX_W-1:0] q_idx,
  input  wire logic [DATA_WIDTH-1:0]     q_value,
  output logic                           empty,
  input  wire logic                      pop,
  output logic [kwm_pkg::KIND_W-1:0]     out_kind,
  output logic [DATA_WIDTH-1:0]          out_merged_value,
  output logic [kwm_pkg::IDX_W-1:0]      out_source_list,
  output logic                           out_round_done,
  output logic                           out_last
);
  import kwm_pkg::*;
  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FW = $clog2(FIFO_DEPTH + 1);
  localparam int LW = $clog2(LISTS);
  localparam int AW = $clog2(LISTS * FIFO_DEPTH);
  localparam int UW = $clog2(LISTS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_PICK = 2'd2;

  logic [1:0]            st_r;
  logic [UW-1:0]         use_r;
  logic [PW-1:0]         rdp_r [LISTS];
  logic [PW-1:0]         wrp_r [LISTS];
  logic [FW-1:0]         fill_r [LISTS];
  logic [DATA_WIDTH-1:0] prev_r [LISTS];
  logic [DATA_WIDTH-1:0] head_r [LISTS];
  logic [LISTS-1:0]      hvalid_r;
  logic [LISTS-1:0]      closed_r, pushed_r;
  logic [LW-1:0]         rdl_r;
  logic [CNT_W-1:0]      n_r;
  logic                  drained_r;
  logic [IDX_W-1:0]      idx_r;

  // output register
  logic                  ov_r;
  logic [KIND_W-1:0]     okind_r;
  logic [DATA_WIDTH-1:0] oval_r;
  logic [IDX_W-1:0]      osrc_r;
  logic                  odone_r, olast_r;

  assign empty            = !ov_r;
  assign out_kind         = okind_r;
  assign out_merged_value = oval_r;
  assign out_source_list  = osrc_r;
  assign out_round_done   = odone_r;
  assign out_last         = olast_r;
  wire   oroom = !ov_r || pop;

  // RAM
  logic                  ram_we;
  logic [AW-1:0]         ram_wa, ram_ra;
  logic [DATA_WIDTH-1:0] ram_rd;
  kwm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(LISTS * FIFO_DEPTH)) u_ram (
    .clk, .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(q_value),
    .rd_addr(ram_ra), .rd_data(ram_rd)
  );

  // request decode
  logic [LISTS-1:0] inuse;
  always_comb begin
    for (int i = 0; i < LISTS; i++) inuse[i] = UW'(i) < use_r;
  end
  wire [LW-1:0] qi     = LW'(q_idx);
  wire          qrange = {{(32-IDX_W){1'b0}}, q_idx} < LISTS;
  wire          bad    = !qrange || !inuse[qi] || closed_r[qi];
  wire          ooo    = pushed_r[qi] && ($signed(q_value) < $signed(prev_r[qi]));
  wire          isfull = fill_r[qi] >= FW'(FIFO_DEPTH);

  // head selection among lists in use
  logic          blocked, any, ended;
  logic [LW-1:0] best;
  always_comb begin
    blocked = 1'b0; any = 1'b0; best = '0; ended = 1'b1;
    for (int i = 0; i < LISTS; i++) begin
      if (inuse[i]) begin
        if (fill_r[i] == '0) begin
          if (!closed_r[i]) blocked = 1'b1;
        end else if (!any || $signed(head_r[i]) <= $signed(head_r[best])) begin
          best = LW'(i); any = 1'b1;
        end
        if (fill_r[i] != '0 || !closed_r[i]) ended = 1'b0;
      end
    end
  end
  wire emit    = !blocked && any && (n_r < CNT_W'(MAX_RESULTS));
  // after one more pop, does the round end?
  logic ended_after;
  always_comb begin
    ended_after = 1'b1;
    for (int i = 0; i < LISTS; i++)
      if (inuse[i] && ((fill_r[i] != '0 && !(LW'(i) == best && fill_r[i] == FW'(1)))
                       || !closed_r[i]))
        ended_after = 1'b0;
  end
  // another emit possible after this one (heads of other lists unchanged)
  wire next_emit = !ended_after && (n_r + 1'b1 < CNT_W'(MAX_RESULTS)) &&
                   !(fill_r[best] == FW'(1) && !closed_r[best]);

  assign q_take = (st_r == ST_IDLE) && q_valid && oroom;

  always_comb begin
    ram_we = 1'b0;
    ram_wa = AW'(qi) * AW'(FIFO_DEPTH) + AW'(wrp_r[qi]);
    // next entry of the list being popped, so its data lands in ST_READ
    ram_ra = AW'(best) * AW'(FIFO_DEPTH) +
             AW'((rdp_r[best] == PW'(FIFO_DEPTH - 1)) ? PW'(0) : rdp_r[best] + 1'b1);
    if (q_take && q_func == FUNC_PUSH && !bad && !ooo && !isfull) ram_we = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; use_r <= UW'(LISTS < 4 ? LISTS : 4);
      closed_r <= '0; pushed_r <= '0; hvalid_r <= '0; ov_r <= 1'b0;
      n_r <= '0; drained_r <= 1'b0; rdl_r <= '0;
      for (int i = 0; i < LISTS; i++) begin
        rdp_r[i] <= '0; wrp_r[i] <= '0; fill_r[i] <= '0; prev_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_data == '0) use_r <= UW'(1);
        else if ({{(32-CFG_W){1'b0}}, cfg_data} > LISTS) use_r <= UW'(LISTS);
        else use_r <= UW'(cfg_data);
      end
      if (pop && ov_r) ov_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          if (q_take) begin
            idx_r <= q_idx; n_r <= '0; drained_r <= 1'b0;
            okind_r <= KIND_CLOSED; osrc_r <= q_idx; odone_r <= 1'b0; olast_r <= 1'b1;
            oval_r <= (q_func == FUNC_PUSH) ? q_value : '0;
            if (bad || (q_func == FUNC_PUSH && (ooo || isfull))) begin
              ov_r <= 1'b1;
              if (!bad) okind_r <= ooo ? KIND_ORDER : KIND_FULL;
            end else begin
              if (q_func == FUNC_PUSH) begin
                wrp_r[qi]  <= (wrp_r[qi] == PW'(FIFO_DEPTH - 1)) ? '0 : wrp_r[qi] + 1'b1;
                fill_r[qi] <= fill_r[qi] + 1'b1;
                prev_r[qi] <= q_value; pushed_r[qi] <= 1'b1;
                if (!hvalid_r[qi] && fill_r[qi] == '0) begin
                  head_r[qi] <= q_value; hvalid_r[qi] <= 1'b1;
                end
              end else closed_r[qi] <= 1'b1;
              st_r <= ST_PICK;
            end
          end
        end
        ST_READ: begin
          // RAM data valid this cycle for list rdl_r
          head_r[rdl_r] <= ram_rd; hvalid_r[rdl_r] <= 1'b1;
          st_r <= ST_PICK;
        end
        default: begin // ST_PICK
          if (oroom) begin
            if (emit) begin
              ov_r <= 1'b1; okind_r <= KIND_MERGED; oval_r <= head_r[best];
              osrc_r <= IDX_W'(best); odone_r <= ended_after;
              olast_r <= !next_emit;
              n_r <= n_r + 1'b1; drained_r <= 1'b1;
              rdp_r[best]  <= (rdp_r[best] == PW'(FIFO_DEPTH - 1)) ? '0 : rdp_r[best] + 1'b1;
              fill_r[best] <= fill_r[best] - 1'b1;
              hvalid_r[best] <= 1'b0;
              if (ended_after) begin
                closed_r <= '0; pushed_r <= '0; hvalid_r <= '0; st_r <= ST_IDLE;
                for (int i = 0; i < LISTS; i++) begin
                  rdp_r[i] <= '0; wrp_r[i] <= '0; fill_r[i] <= '0; prev_r[i] <= '0;
                end
              end else if (!next_emit) st_r <= ST_IDLE;
              else if (fill_r[best] > FW'(1)) begin
                rdl_r <= best; st_r <= ST_READ;
              end
            end else begin
              if (ended) begin
                if (!drained_r) begin
                  ov_r <= 1'b1; okind_r <= KIND_EMPTY; oval_r <= '0; osrc_r <= idx_r;
                  odone_r <= 1'b1; olast_r <= 1'b1;
                end
                closed_r <= '0; pushed_r <= '0; hvalid_r <= '0;
                for (int i = 0; i < LISTS; i++) begin
                  rdp_r[i] <= '0; wrp_r[i] <= '0; fill_r[i] <= '0; prev_r[i] <= '0;
                end
              end
              st_r <= ST_IDLE;
            end
          end
        end
      endcase
      // a head left stale by a pop needs refetch before the next request
      if (st_r == ST_PICK && oroom && emit && !ended_after && !next_emit &&
          fill_r[best] > FW'(1)) begin
        rdl_r <= best; st_r <= ST_READ;
      end
      if (st_r == ST_READ && n_r == '0 && drained_r) st_r <= ST_IDLE;
    end
  end
endmodule
`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for k_way_sorted_merge: drives push/close requests
// through the input queue port, predicts the merged stream and refusals,
// and compares every result field with the prediction, oldest first.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
  import kwm_pkg::*;

  localparam int NL = LISTS_DEF;
  localparam int DEPTH = FIFO_DEPTH_DEF;
  localparam int DW = DATA_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic          func;
    logic [1:0]    idx;
    logic [DW-1:0] value;
  } request_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DW-1:0]     value;
    logic [1:0]        src;
    logic              round_done;
    logic              last;
  } merge_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_lists_in_use = 3'd4;
  logic push = 1'b0;
  logic full;
  logic in_func = 1'b0;
  logic [1:0] in_list_index = 2'd0;
  logic [DW-1:0] in_value = '0;
  logic empty;
  logic pop = 1'b0;
  logic [KIND_W-1:0] out_kind;
  logic [DW-1:0] out_merged_value;
  logic [1:0] out_source_list;
  logic out_round_done;
  logic out_last;

  k_way_sorted_merge uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_lists_in_use(cfg_lists_in_use),
    .push(push), .full(full), .in_func(in_func), .in_list_index(in_list_index),
    .in_value(in_value), .empty(empty), .pop(pop), .out_kind(out_kind),
    .out_merged_value(out_merged_value), .out_source_list(out_source_list),
    .out_round_done(out_round_done), .out_last(out_last)
  );

  // predictor state
  logic [DW-1:0] list_fifo [NL][$];
  logic [NL-1:0] closed_mask;
  logic [NL-1:0] pushed_mask;
  logic [DW-1:0] prev_value [NL];
  int active_lists;

  request_t pending_requests[$];
  merge_result_t expected_results[$];
  int errors = 0;
  int cycles = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("k_way_sorted_merge: mismatch");
      $finish;
    end
  end

  function automatic void clear_round();
    for (int i = 0; i < NL; i++) begin
      list_fifo[i].delete();
      prev_value[i] = '0;
    end
    closed_mask = '0;
    pushed_mask = '0;
  endfunction

  function automatic void add_result(logic [KIND_W-1:0] k, logic [DW-1:0] v, int s);
    merge_result_t r;
    r.kind = k;
    r.value = v;
    r.src = s[1:0];
    r.round_done = 1'b0;
    r.last = 1'b0;
    expected_results.push_back(r);
  endfunction

  // apply one accepted request to the predictor
  function automatic void predict_merge(request_t rq);
    int n;
    int drained;
    int first;
    int best;
    bit blocked;
    bit ended;
    int i;
    n = 0;
    drained = 0;
    first = expected_results.size();
    i = rq.idx;
    if (rq.func == FUNC_PUSH) begin
      if (i >= active_lists || closed_mask[i]) begin
        add_result(KIND_CLOSED, rq.value, i);
        n = 1;
      end else if (pushed_mask[i] && $signed(rq.value) < $signed(prev_value[i])) begin
        add_result(KIND_ORDER, rq.value, i);
        n = 1;
      end else if (list_fifo[i].size() >= DEPTH) begin
        add_result(KIND_FULL, rq.value, i);
        n = 1;
      end
      if (n) begin
        expected_results[first].last = 1'b1;
        return;
      end
      list_fifo[i].push_back(rq.value);
      prev_value[i] = rq.value;
      pushed_mask[i] = 1'b1;
    end else begin
      if (i >= active_lists || closed_mask[i]) begin
        add_result(KIND_CLOSED, '0, i);
        expected_results[first].last = 1'b1;
        return;
      end
      closed_mask[i] = 1'b1;
    end
    while (n < MAX_RESULTS) begin
      best = -1;
      blocked = 0;
      for (int j = 0; j < active_lists; j++) begin
        if (list_fifo[j].size() == 0) begin
          if (!closed_mask[j]) blocked = 1;
        end else if (best < 0 ||
                     $signed(list_fifo[j][0]) <= $signed(list_fifo[best][0])) begin
          best = j;
        end
      end
      if (blocked || best < 0) break;
      add_result(KIND_MERGED, list_fifo[best].pop_front(), best);
      n++;
      drained++;
    end
    ended = 1;
    for (int j = 0; j < active_lists; j++)
      if (list_fifo[j].size() != 0 || !closed_mask[j]) ended = 0;
    if (ended) begin
      if (drained == 0 && n < MAX_RESULTS) begin
        add_result(KIND_EMPTY, '0, i);
        n++;
      end
      if (n > 0) expected_results[first + n - 1].round_done = 1'b1;
      clear_round();
    end
    if (n > 0) expected_results[first + n - 1].last = 1'b1;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) begin
        predict_merge(pending_requests.pop_front());
        requests_sent <= requests_sent + 1;
      end
      if ((push && full) || (pending_requests.size() > 0 &&
          (send_idle_pct == 0 || $urandom_range(99) >= send_idle_pct))) begin
        if (!(push && full)) begin
          in_func <= pending_requests[0].func;
          in_list_index <= pending_requests[0].idx;
          in_value <= pending_requests[0].value;
        end
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    merge_result_t exp_r;
    if (rst_n) begin
      if (pop && !empty) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: kind %0d value %0d", out_kind,
                 $signed(out_merged_value));
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_kind !== exp_r.kind) begin
            $error("kind: expected %0d actual %0d", exp_r.kind, out_kind);
            errors++;
          end
          if (out_merged_value !== exp_r.value) begin
            $error("merged_value: expected %0d actual %0d", $signed(exp_r.value),
                   $signed(out_merged_value));
            errors++;
          end
          if (out_source_list !== exp_r.src) begin
            $error("source_list: expected %0d actual %0d", exp_r.src, out_source_list);
            errors++;
          end
          if (out_round_done !== exp_r.round_done) begin
            $error("round_done: expected %0d actual %0d", exp_r.round_done,
                   out_round_done);
            errors++;
          end
          if (out_last !== exp_r.last) begin
            $error("last: expected %0d actual %0d", exp_r.last, out_last);
            errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        pop <= 1'b0;
      end else begin
        pop <= (recv_idle_pct == 0 || $urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic void queue_request(logic f, int idx, logic [DW-1:0] v);
    request_t rq;
    rq.func = f;
    rq.idx = idx[1:0];
    rq.value = v;
    pending_requests.push_back(rq);
  endfunction

  // one well-formed round: ascending values per list, then close every list
  function automatic void queue_round(int n_lists, int per_list);
    int base [NL];
    int total;
    int l;
    for (int j = 0; j < NL; j++) base[j] = $urandom_range(2000) - 1000;
    total = n_lists * per_list;
    for (int k = 0; k < total; k++) begin
      l = $urandom_range(n_lists - 1);
      if ($urandom_range(19) == 0) begin
        // noise: random list, random value, may be refused
        queue_request(FUNC_PUSH, $urandom_range(3), $urandom);
      end else begin
        base[l] += $urandom_range(3) == 0 ? 0 : $urandom_range(50);
        queue_request(FUNC_PUSH, l, base[l]);
      end
    end
    for (int j = n_lists - 1; j >= 0; j--) queue_request(FUNC_CLOSE, j, $urandom);
    if ($urandom_range(4) == 0) queue_request(FUNC_CLOSE, $urandom_range(3), '0);
  endfunction

  task automatic wait_idle();
    while (pending_requests.size() != 0 || push || expected_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_lists(int v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_lists_in_use <= v[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    active_lists = (v == 0) ? 1 : (v > NL ? NL : v);
  endtask

  initial begin
    int phase_items;
    clear_round();
    active_lists = NL;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, refusals, overflow, empty round
    queue_request(FUNC_PUSH, 0, 32'h8000_0000);
    queue_request(FUNC_PUSH, 1, 32'h7fff_ffff);
    queue_request(FUNC_PUSH, 1, 32'h0000_0000);   // out of order
    queue_request(FUNC_PUSH, 2, 32'h7fff_ffff);
    queue_request(FUNC_PUSH, 3, 32'h7fff_ffff);   // ties: higher list first
    queue_request(FUNC_PUSH, 0, 32'h7fff_ffff);
    queue_request(FUNC_CLOSE, 2, '0);
    queue_request(FUNC_CLOSE, 2, '0);             // already closed
    queue_request(FUNC_PUSH, 2, 32'h7fff_ffff);   // push to closed list
    queue_request(FUNC_CLOSE, 0, '0);
    queue_request(FUNC_CLOSE, 1, '0);
    queue_request(FUNC_CLOSE, 3, '0);
    for (int k = 0; k < 17; k++) queue_request(FUNC_PUSH, 0, k); // last one is full
    wait_idle();
    set_lists(0);                                 // counts as one list
    queue_request(FUNC_PUSH, 1, 5);               // unused list
    queue_request(FUNC_CLOSE, 3, '0);
    queue_request(FUNC_PUSH, 0, 32'hffff_ffff);
    queue_request(FUNC_CLOSE, 0, '0);             // leftover values drain
    queue_request(FUNC_CLOSE, 0, '0);             // empty round
    wait_idle();

    // random phases over several settings and idle profiles
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 19 : (p == 1) ? 47 : 0;
      recv_idle_pct = (p == 0) ? 47 : (p == 1) ? 19 : 0;
      set_lists(p == 0 ? 7 : p == 1 ? 2 : $urandom_range(3) + 1);
      phase_items = 0;
      while (phase_items < 65) begin
        queue_round(active_lists, $urandom_range(4) + 1);
        phase_items = pending_requests.size();
        if (phase_items < 65 && $urandom_range(2) == 0)
          queue_request(FUNC_PUSH, $urandom_range(3), $urandom);
      end
      if (p == 1) hold_off = 300;                 // stall receiver, let input back up
      wait_idle();
    end
    set_lists(4);
    queue_round(4, 6);
    wait_idle();

    $display("requests accepted: %0d, results checked: %0d", requests_sent, results_seen);
    if (errors == 0) begin
      $display("k_way_sorted_merge: match");
    end else begin
      $display("k_way_sorted_merge: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire
